// ===== src/gtsu_pkg.sv =====
// Shared types and codes for the GIF tag stream unpacker.
// No dependencies; imported by the unpacker top level and its checker.
package gtsu_pkg;

  // result kinds, carried on out_tuser
  localparam logic [1:0] KIND_PACKED  = 2'd0;
  localparam logic [1:0] KIND_REGLIST = 2'd1;
  localparam logic [1:0] KIND_IMAGE   = 2'd2;
  localparam logic [1:0] KIND_TAG     = 2'd3;

  // tag FLG codes (code 3 behaves as image)
  localparam logic [1:0] FMT_PACKED  = 2'd0;
  localparam logic [1:0] FMT_REGLIST = 2'd1;

  // result queue depth, power of two, at least 2
  localparam int RESULT_DEPTH = 4;

  // out_tdata bit positions
  localparam int OD_EOP = 132;
  localparam int OD_PW  = 133;
  localparam int OD_QR  = 134;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  reg_index;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        end_of_packet;
    logic        prim_write;
    logic        q_reset;
    logic        last;
  } result_t;

endpackage

// ===== src/gif_tag_stream_unpacker_unit.sv =====
// GIF tag stream unpacker: tag decode, packed/reglist/image unpacking.
// Depends on gtsu_pkg (result_t, kind and format codes).
//
// Path: input register, then the result queue, whose head drives the output.
// Throughput: one quadword per cycle for tags, packed and image data while the
// queue has room; two-write reglist quadwords are slowed by the single output port.
// Reset (rst_n low, synchronous): loop/descriptor state and result queue cleared.
module gif_tag_stream_unpacker_unit
  import gtsu_pkg::*;
#(
  parameter int DEPTH = RESULT_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: [63:0] qw_low, [127:64] qw_high
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  // out_tdata: [3:0] reg_index, [67:4] data_low, [131:68] data_high,
  //            [132] end_of_packet, [133] prim_write, [134] q_reset, [135] zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,
  // out_tuser: [1:0] kind
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // input register
  logic         in_v_r;
  logic [63:0]  lo_r, hi_r;

  // unpacker state
  logic [14:0]  loops_r, loops_nxt;
  logic         eop_r, eop_nxt;
  logic [1:0]   fmt_r, fmt_nxt;
  logic [63:0]  dlist_r, dlist_nxt;
  logic [6:0]   dpos_r, dpos_nxt;
  logic [6:0]   dtot_r, dtot_nxt;

  // result queue
  result_t              rq_mem [DEPTH];
  logic [PTR_W-1:0]     wr_r, rd_r;
  logic [CNT_W-1:0]     cnt_r;

  logic       proc;
  logic       pop;
  logic [1:0] n_push;
  result_t    res0, res1;

  // queue must have room for a two-write reglist quadword
  assign proc      = in_v_r && (cnt_r <= CNT_W'(DEPTH - 2));
  assign in_tready = !in_v_r || proc;
  assign pop       = out_tvalid && out_tready;

  // two chained descriptor steps; the second only used by reglist
  logic [3:0]  nib0, nib1;
  logic [6:0]  pa, pb, pos1, pos2;
  logic        wrap0, wrap1;
  logic [14:0] loops1, loops2;

  assign nib0   = 4'(dlist_r >> dpos_r[5:0]);
  assign pa     = dpos_r + 7'd4;
  assign wrap0  = pa >= dtot_r;
  assign pos1   = wrap0 ? 7'd0 : pa;
  assign loops1 = (wrap0 && loops_r != 15'd0) ? loops_r - 15'd1 : loops_r;

  assign nib1   = 4'(dlist_r >> pos1[5:0]);
  assign pb     = pos1 + 7'd4;
  assign wrap1  = pb >= dtot_r;
  assign pos2   = wrap1 ? 7'd0 : pb;
  assign loops2 = (wrap1 && loops1 != 15'd0) ? loops1 - 15'd1 : loops1;

  always_comb begin
    loops_nxt = loops_r;
    eop_nxt   = eop_r;
    fmt_nxt   = fmt_r;
    dlist_nxt = dlist_r;
    dpos_nxt  = dpos_r;
    dtot_nxt  = dtot_r;
    res0      = '0;
    res1      = '0;
    n_push    = 2'd0;
    if (proc) begin
      res0.end_of_packet = eop_r;
      res1.end_of_packet = eop_r;
      if (loops_r == 15'd0) begin
        // tag quadword
        loops_nxt = lo_r[14:0];
        eop_nxt   = lo_r[15];
        fmt_nxt   = lo_r[59:58];
        // NREG of zero means sixteen registers
        dtot_nxt  = (lo_r[63:60] == 4'd0) ? 7'd64 : {1'b0, lo_r[63:60], 2'b00};
        if (lo_r[59:58] == FMT_PACKED || lo_r[59:58] == FMT_REGLIST) begin
          dlist_nxt = hi_r;
          dpos_nxt  = 7'd0;
        end
        res0.kind          = KIND_TAG;
        res0.data_low      = {53'd0, lo_r[57:47]};
        res0.end_of_packet = lo_r[15];
        res0.prim_write    = (lo_r[59:58] == FMT_PACKED) && lo_r[46];
        res0.q_reset       = 1'b1;
        res0.last          = 1'b1;
        n_push             = 2'd1;
      end else begin
        case (fmt_r)
          FMT_PACKED: begin
            loops_nxt      = loops1;
            dpos_nxt       = pos1;
            res0.kind      = KIND_PACKED;
            res0.reg_index = nib0;
            res0.data_low  = lo_r;
            res0.data_high = hi_r;
            res0.last      = 1'b1;
            n_push         = 2'd1;
          end
          FMT_REGLIST: begin
            res0.kind      = KIND_REGLIST;
            res0.reg_index = nib0;
            res0.data_low  = lo_r;
            if (loops1 == 15'd0) begin
              // loops end on the low half: high half is padding
              loops_nxt = loops1;
              dpos_nxt  = pos1;
              res0.last = 1'b1;
              n_push    = 2'd1;
            end else begin
              loops_nxt      = loops2;
              dpos_nxt       = pos2;
              res1.kind      = KIND_REGLIST;
              res1.reg_index = nib1;
              res1.data_low  = hi_r;
              res1.last      = 1'b1;
              n_push         = 2'd2;
            end
          end
          default: begin
            // image, FLG 3 included
            loops_nxt      = loops_r - 15'd1;
            res0.kind      = KIND_IMAGE;
            res0.data_low  = lo_r;
            res0.data_high = hi_r;
            res0.last      = 1'b1;
            n_push         = 2'd1;
          end
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      lo_r <= in_tdata[63:0];
      hi_r <= in_tdata[127:64];
    end
  end

  // unpacker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loops_r <= '0;
      eop_r   <= 1'b0;
      fmt_r   <= '0;
      dlist_r <= '0;
      dpos_r  <= '0;
      dtot_r  <= '0;
    end else begin
      loops_r <= loops_nxt;
      eop_r   <= eop_nxt;
      fmt_r   <= fmt_nxt;
      dlist_r <= dlist_nxt;
      dpos_r  <= dpos_nxt;
      dtot_r  <= dtot_nxt;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(n_push);
      rd_r  <= rd_r + PTR_W'(pop);
      cnt_r <= cnt_r + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      rq_mem[wr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      rq_mem[wr_r + PTR_W'(1)] <= res1;
    end
  end

  result_t head;
  assign head       = rq_mem[rd_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {1'b0, head.q_reset, head.prim_write, head.end_of_packet,
                       head.data_high, head.data_low, head.reg_index};

endmodule

// ===== src/gtsu_checker.sv =====
// Port-level checks for the GIF tag stream unpacker, bound to its top level.
// Depends on gtsu_pkg (kind codes, out_tdata bit positions).
module gtsu_checker
  import gtsu_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a tag result always resets Q and is the only result of its quadword
  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TAG |-> out_tdata[OD_QR] && out_tlast)
    else $error("tag result without q_reset or last");

  // data results never carry tag flags
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_TAG |-> !out_tdata[OD_QR] && !out_tdata[OD_PW])
    else $error("data result carries tag flags");

  // first half of a reglist pair is followed at once by its second half
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_REGLIST && !out_tlast
    |=> out_tvalid && out_tuser == KIND_REGLIST)
    else $error("reglist pair broken");

endmodule

bind gif_tag_stream_unpacker_unit gtsu_checker u_gtsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for gif_tag_stream_unpacker_unit: a directed tag/data table, then
// random GIF packets under varying idle and stall patterns. Uses gtsu_pkg and the unpacker RTL.
module tb_top;
  import gtsu_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int HOLD_CYCLES = 300;   // long output hold-off to back the block up
  localparam int N_ITEMS     = 1100;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    bit          typed;   // want holds a hand-written expectation
    result_t     want;
  } stim_row_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  gif_tag_stream_unpacker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // bench copy of the unpacker state
  logic [14:0] loops_left_q    = '0;
  logic        pkt_eop_q       = 1'b0;
  logic [1:0]  fmt_q           = FMT_PACKED;
  logic [63:0] reg_list_q      = '0;
  logic [6:0]  reg_pos_q       = '0;
  logic [6:0]  reg_bits_q      = '0;

  result_t     due_results[$];   // writes the unpacker still owes, oldest first
  stim_row_t   dir_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int mismatches    = 0;
  int stall_cycles  = 0;
  int kind_seen[4]  = '{0, 0, 0, 0};
  result_t got_res;
  result_t want_res;

  // ---------------------------------------------------------------------------
  // Unpacker model
  // ---------------------------------------------------------------------------

  // Current register descriptor; a wrap of the list closes one loop.
  task automatic take_descriptor(output logic [3:0] idx);
    idx = 4'(reg_list_q >> reg_pos_q[5:0]);
    reg_pos_q = reg_pos_q + 7'd4;
    if (reg_pos_q >= reg_bits_q) begin
      reg_pos_q = '0;
      if (loops_left_q != 0) loops_left_q = loops_left_q - 15'd1;
    end
  endtask

  task automatic unpack_quadword(input logic [63:0] lo, input logic [63:0] hi,
                                 output result_t r0, output result_t r1, output int n);
    logic [3:0] idx;
    logic [6:0] nbits;
    r0 = '0;
    r1 = '0;
    n  = 1;
    if (loops_left_q == 0) begin
      // tag: NLOOP[14:0] EOP[15] PRE[46] PRIM[57:47] FLG[59:58] NREG[63:60]
      nbits = {1'b0, lo[63:60], 2'b00};
      if (nbits == 0) nbits = 7'd64;
      loops_left_q = lo[14:0];
      pkt_eop_q    = lo[15];
      fmt_q        = lo[59:58];
      reg_bits_q   = nbits;
      // image tags leave the descriptor list and position alone
      if (lo[59:58] == FMT_PACKED || lo[59:58] == FMT_REGLIST) begin
        reg_list_q = hi;
        reg_pos_q  = '0;
      end
      r0.kind          = KIND_TAG;
      r0.data_low      = {53'd0, lo[57:47]};
      r0.end_of_packet = lo[15];
      r0.prim_write    = (lo[59:58] == FMT_PACKED) && lo[46];
      r0.q_reset       = 1'b1;
      r0.last          = 1'b1;
    end else if (fmt_q == FMT_PACKED) begin
      take_descriptor(idx);
      r0.kind          = KIND_PACKED;
      r0.reg_index     = idx;
      r0.data_low      = lo;
      r0.data_high     = hi;
      r0.end_of_packet = pkt_eop_q;
      r0.last          = 1'b1;
    end else if (fmt_q == FMT_REGLIST) begin
      take_descriptor(idx);
      r0.kind          = KIND_REGLIST;
      r0.reg_index     = idx;
      r0.data_low      = lo;
      r0.end_of_packet = pkt_eop_q;
      // loops done after the low half: high half is padding
      if (loops_left_q == 0) begin
        r0.last = 1'b1;
      end else begin
        take_descriptor(idx);
        r1.kind          = KIND_REGLIST;
        r1.reg_index     = idx;
        r1.data_low      = hi;
        r1.end_of_packet = pkt_eop_q;
        r1.last          = 1'b1;
        n = 2;
      end
    end else begin
      // image, also FLG 3
      loops_left_q     = loops_left_q - 15'd1;
      r0.kind          = KIND_IMAGE;
      r0.data_low      = lo;
      r0.data_high     = hi;
      r0.end_of_packet = pkt_eop_q;
      r0.last          = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] tag_word(input logic [14:0] nloop, input logic eop,
                                           input logic pre, input logic [10:0] prim,
                                           input logic [1:0] flg, input logic [3:0] nreg);
    return {nreg, flg, prim, pre, 30'd0, eop, nloop};
  endfunction

  function automatic result_t tag_want(input logic [10:0] prim, input logic eop,
                                       input logic pw);
    result_t r;
    r = '0;
    r.kind          = KIND_TAG;
    r.data_low      = {53'd0, prim};
    r.end_of_packet = eop;
    r.prim_write    = pw;
    r.q_reset       = 1'b1;
    r.last          = 1'b1;
    return r;
  endfunction

  function automatic result_t img_want(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic eop);
    result_t r;
    r = '0;
    r.kind          = KIND_IMAGE;
    r.data_low      = lo;
    r.data_high     = hi;
    r.end_of_packet = eop;
    r.last          = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [63:0] lo, input logic [63:0] hi,
                                    input bit typed, input result_t want);
    stim_row_t s;
    s.lo    = lo;
    s.hi    = hi;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // One input transaction; the model runs on acceptance.
  task automatic send_quadword(input logic [63:0] lo, input logic [63:0] hi,
                               input bit typed, input result_t want);
    result_t r0;
    result_t r1;
    int      n;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    unpack_quadword(lo, hi, r0, r1, n);
    if (typed) begin
      due_results.push_back(want);
    end else begin
      due_results.push_back(r0);
      if (n == 2) due_results.push_back(r1);
    end
  endtask

  // Tag with random content and a short loop count, then exactly the data it
  // consumes. Some tags carry NLOOP 0 and are followed straight by another tag.
  task automatic send_packet();
    logic [63:0] lo;
    logic [63:0] hi;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    if ($urandom_range(99) < 15)
      lo[14:0] = '0;
    else if (lo[59:58] != FMT_PACKED && lo[59:58] != FMT_REGLIST)
      lo[14:0] = 15'($urandom_range(1, 12));
    else
      lo[14:0] = 15'($urandom_range(1, 4));
    send_quadword(lo, hi, 1'b0, '0);
    while (loops_left_q != 0)
      send_quadword({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, '0);
  endtask

  task automatic run_random(input int upto);
    while (items_sent < upto) send_packet();
  endtask

  // sender stays quiet until every owed write has come out
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random backpressure plus an occasional long hold
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: each output transaction against the oldest owed write.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.kind          = out_tuser;
      got_res.reg_index     = out_tdata[3:0];
      got_res.data_low      = out_tdata[67:4];
      got_res.data_high     = out_tdata[131:68];
      got_res.end_of_packet = out_tdata[OD_EOP];
      got_res.prim_write    = out_tdata[OD_PW];
      got_res.q_reset       = out_tdata[OD_QR];
      got_res.last          = out_tlast;
      kind_seen[out_tuser]++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d lo %h", $realtime,
                   got_res.kind, got_res.data_low);
      end else begin
        want_res = due_results.pop_front();
        if (got_res.kind !== want_res.kind || got_res.reg_index !== want_res.reg_index ||
            got_res.data_low !== want_res.data_low ||
            got_res.data_high !== want_res.data_high ||
            got_res.end_of_packet !== want_res.end_of_packet ||
            got_res.prim_write !== want_res.prim_write ||
            got_res.q_reset !== want_res.q_reset || got_res.last !== want_res.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("%0t: mismatch exp/got kind %0d/%0d reg %h/%h lo %h/%h hi %h/%h",
                   $realtime,
                   want_res.kind, got_res.kind, want_res.reg_index, got_res.reg_index,
                   want_res.data_low, got_res.data_low,
                   want_res.data_high, got_res.data_high);
            $display(" eop %b/%b pw %b/%b qr %b/%b last %b/%b",
                     want_res.end_of_packet, got_res.end_of_packet,
                     want_res.prim_write, got_res.prim_write,
                     want_res.q_reset, got_res.q_reset, want_res.last, got_res.last);
          end
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either side means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d writes owed",
               stall_cycles, due_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    send_idle_pct = 35;
    recv_idle_pct = 79;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // packed tag straight after reset, PRE set, PRIM all ones, two registers
    dir_rows.push_back(row(tag_word(15'd1, 1'b1, 1'b1, 11'h7ff, FMT_PACKED, 4'd2),
                           64'h0000_0000_0000_00a5, 1'b1, tag_want(11'h7ff, 1'b1, 1'b1)));
    dir_rows.push_back(row('1, '1, 1'b0, '0));
    dir_rows.push_back(row('0, '0, 1'b0, '0));
    // zero loop count, reglist: PRE ignored, next quadword is a tag again
    dir_rows.push_back(row(tag_word(15'd0, 1'b0, 1'b1, 11'h155, FMT_REGLIST, 4'd0),
                           '1, 1'b1, tag_want(11'h155, 1'b0, 1'b0)));
    // reglist, three registers, one loop: three writes, then the padding half dropped
    dir_rows.push_back(row(tag_word(15'd1, 1'b0, 1'b0, 11'h2aa, FMT_REGLIST, 4'd3),
                           64'h0000_0000_0000_0fed, 1'b1, tag_want(11'h2aa, 1'b0, 1'b0)));
    dir_rows.push_back(row(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0, '0));
    dir_rows.push_back(row(64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe, 1'b0, '0));
    // format three handled as image; descriptor state kept
    dir_rows.push_back(row(tag_word(15'd2, 1'b1, 1'b1, 11'h001, 2'd3, 4'd5),
                           '1, 1'b1, tag_want(11'h001, 1'b1, 1'b0)));
    dir_rows.push_back(row('1, '1, 1'b1, img_want('1, '1, 1'b1)));
    dir_rows.push_back(row('0, '0, 1'b1, img_want('0, '0, 1'b0 | 1'b1)));
    dir_rows.push_back(row(tag_word(15'd1, 1'b0, 1'b0, 11'h000, 2'd2, 4'd0),
                           64'hdead_beef_0bad_f00d, 1'b1, tag_want(11'h000, 1'b0, 1'b0)));
    dir_rows.push_back(row(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1,
                           img_want(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0)));
    // reglist with NREG 0 (sixteen registers): eight full quadwords
    dir_rows.push_back(row(tag_word(15'd1, 1'b1, 1'b0, 11'h400, FMT_REGLIST, 4'd0),
                           64'hfedc_ba98_7654_3210, 1'b1, tag_want(11'h400, 1'b1, 1'b0)));
    dir_rows.push_back(row(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002, 1'b0, '0));
    dir_rows.push_back(row(64'h0000_0000_0000_0003, 64'h0000_0000_0000_0004, 1'b0, '0));
    dir_rows.push_back(row(64'h0000_0000_0000_0005, 64'h0000_0000_0000_0006, 1'b0, '0));
    dir_rows.push_back(row(64'h0000_0000_0000_0007, 64'h0000_0000_0000_0008, 1'b0, '0));
    dir_rows.push_back(row(64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff, 1'b0, '0));
    dir_rows.push_back(row(64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00, 1'b0, '0));
    dir_rows.push_back(row(64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0, 1'b0, '0));
    dir_rows.push_back(row('1, '0, 1'b0, '0));
    // one register, three loops: second quadword ends on its low half
    dir_rows.push_back(row(tag_word(15'd3, 1'b0, 1'b1, 11'h000, FMT_REGLIST, 4'd1),
                           64'h0000_0000_0000_0007, 1'b1, tag_want(11'h000, 1'b0, 1'b0)));
    dir_rows.push_back(row(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 1'b0, '0));
    dir_rows.push_back(row(64'h9999_aaaa_bbbb_cccc, 64'hdddd_eeee_ffff_0000, 1'b0, '0));
    // zero-loop packed tag with PRE: primitive write, no data follows
    dir_rows.push_back(row(tag_word(15'd0, 1'b1, 1'b1, 11'h7ff, FMT_PACKED, 4'hf),
                           '0, 1'b1, tag_want(11'h7ff, 1'b1, 1'b1)));

    foreach (dir_rows[i])
      send_quadword(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].typed, dir_rows[i].want);

    // phase 1: slow receiver
    run_random(N_ITEMS / 3);
    wait_drained();

    // phase 2: slow sender, plus a long output hold while input keeps coming
    send_idle_pct = 79;
    recv_idle_pct = 35;
    hold_asks++;
    run_random(2 * N_ITEMS / 3);
    wait_drained();

    // phase 3: full rate both sides, another long hold to fill the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    run_random(N_ITEMS);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d quadwords: %0d tags, %0d packed, %0d reglist, %0d image writes",
             items_sent, kind_seen[KIND_TAG], kind_seen[KIND_PACKED],
             kind_seen[KIND_REGLIST], kind_seen[KIND_IMAGE]);
    $display("idle mixes 35/79, 79/35 and none, %0d long output holds, %0d mismatches",
             hold_asks, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/gtsu_pkg.sv
src/gif_tag_stream_unpacker_unit.sv
src/gtsu_checker.sv
test/tb_top.sv
